// ----- design/lags_pkg.sv -----
package lags_pkg;

  // default grid bounds
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // register file
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = 2'd1;
  localparam int GRID_SIZE_RST = 64;

  // item fields
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_ACC_RD,
    S_ACC_MOD,
    S_GEN_RD0,
    S_GEN_LD0,
    S_GEN_RD,
    S_GEN_LD,
    S_GEN_CALC,
    S_GEN_CNT,
    S_DONE
  } state_t;

endpackage

// ----- design/life_automaton_grid_step.sv -----
// Channel  Direction  Ports                               Payload
// in_      slave      in_tvalid/in_tready/in_tdata        request item
// out_     master     out_tvalid/out_tready/out_tdata     result item
// cfg_     write      cfg_we/cfg_addr/cfg_wdata           grid_rows, grid_cols
//
// The grid lives in a row-wide memory (MAX_ROWS words of MAX_COLS bits, registered read).
// Write/read: read row, modify/write back, result; an address error skips the access.
// Clear zeroes all words. Advance: rows rewritten in turn, column-serial live-cell count.
// Reset and every grid_rows/grid_cols write run a clearing pass, in_tready low.
// One item at a time; a finished result waits in the output register while the next is taken.
module life_automaton_grid_step
  import lags_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] req_type, [7:2] row, [13:8] col, [14] write_value, [15] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] read_value, [1] any_live, [2] address_error, [7:3] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int LCW = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int RCW = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;
  localparam int CCW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int RXW = (RW > ROW_W) ? RW : ROW_W;
  localparam int CXW = (CW > COL_W) ? CW : COL_W;
  localparam int RST_ROWS = (GRID_SIZE_RST == 0) ? 1 :
                            ((GRID_SIZE_RST > MAX_ROWS) ? MAX_ROWS : GRID_SIZE_RST);
  localparam int RST_COLS = (GRID_SIZE_RST == 0) ? 1 :
                            ((GRID_SIZE_RST > MAX_COLS) ? MAX_COLS : GRID_SIZE_RST);

  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] mem_rdata_r;
  logic                mem_re;
  logic [RAW-1:0]      mem_raddr;
  logic                mem_we;
  logic [RAW-1:0]      mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;

  state_t state_r, state_nxt;

  logic [RW-1:0]   rows_r;
  logic [CW-1:0]   cols_r;
  logic [LCW-1:0]  live_cnt_r;
  req_t            req_type_r;
  logic [ROW_W-1:0] req_row_r;
  logic [COL_W-1:0] req_col_r;
  logic            req_wval_r;
  logic [RAW-1:0]  clr_row_r;
  logic            clr_req_r;
  logic [RAW-1:0]  gen_row_r;
  logic [CAW-1:0]  col_cnt_r;
  logic [MAX_COLS-1:0] prev_r, cur_r, nxt_r, new_row_r;
  logic            res_rd_r, res_err_r;
  logic            out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic            in_fire;
  logic            cfg_hit;
  logic [RW-1:0]   rows_clamp;
  logic [CW-1:0]   cols_clamp;
  logic [RCW-1:0]  cfg_rows_ext;
  logic [CCW-1:0]  cfg_cols_ext;
  logic            addr_err;
  logic            clr_last;
  logic            gen_last_row;
  logic            gen_last_col;
  logic            done_load;
  logic            acc_bit;
  logic [MAX_COLS-1:0] acc_word;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS+1:0] pv, cv, nv;
  logic [3:0]          nb_cnt [MAX_COLS];
  logic [MAX_COLS-1:0] gen_word;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // size registers saturate: zero reads as one, above the bound reads as the bound
  assign cfg_hit      = cfg_we && ((cfg_addr == REG_GRID_ROWS) || (cfg_addr == REG_GRID_COLS));
  assign cfg_rows_ext = RCW'(cfg_wdata);
  assign cfg_cols_ext = CCW'(cfg_wdata);
  always_comb begin
    if (cfg_wdata == '0) begin
      rows_clamp = RW'(1);
      cols_clamp = CW'(1);
    end else begin
      rows_clamp = (cfg_rows_ext > RCW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_rows_ext);
      cols_clamp = (cfg_cols_ext > CCW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cfg_cols_ext);
    end
  end

  assign addr_err     = (RXW'(req_row_r) >= RXW'(rows_r)) || (CXW'(req_col_r) >= CXW'(cols_r));
  assign clr_last     = (clr_row_r == RAW'(MAX_ROWS - 1));
  assign gen_last_row = ((RW'(gen_row_r) + RW'(1)) == rows_r);
  assign gen_last_col = ((CW'(col_cnt_r) + CW'(1)) == cols_r);
  assign done_load    = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign acc_bit = mem_rdata_r[CAW'(req_col_r)];
  always_comb begin
    acc_word = mem_rdata_r;
    acc_word[CAW'(req_col_r)] = req_wval_r;
  end

  // next generation of one row from the three old rows around it
  assign pv = {1'b0, prev_r, 1'b0};
  assign cv = {1'b0, cur_r, 1'b0};
  assign nv = {1'b0, nxt_r, 1'b0};
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (CW'(c) < cols_r);
      nb_cnt[c] = 4'(pv[c]) + 4'(pv[c+1]) + 4'(pv[c+2]) + 4'(cv[c]) + 4'(cv[c+2])
                + 4'(nv[c]) + 4'(nv[c+1]) + 4'(nv[c+2]);
      gen_word[c] = col_mask[c] &&
                    ((nb_cnt[c] == BIRTH_COUNT) || (cur_r[c] && (nb_cnt[c] == SURVIVE_LOW)));
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_hit) begin
      state_nxt = S_CLEAR;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (req_t'(in_tdata[1:0]))
              REQ_WRITE, REQ_READ: state_nxt = S_ACC_RD;
              REQ_ADVANCE:         state_nxt = S_GEN_RD0;
              REQ_CLEAR:           state_nxt = S_CLEAR;
              default:             state_nxt = S_IDLE;
            endcase
          end
        end
        S_CLEAR:    if (clr_last) state_nxt = clr_req_r ? S_DONE : S_IDLE;
        S_ACC_RD:   state_nxt = addr_err ? S_DONE : S_ACC_MOD;
        S_ACC_MOD:  state_nxt = S_DONE;
        S_GEN_RD0:  state_nxt = S_GEN_LD0;
        S_GEN_LD0:  state_nxt = S_GEN_RD;
        S_GEN_RD:   state_nxt = S_GEN_LD;
        S_GEN_LD:   state_nxt = S_GEN_CALC;
        S_GEN_CALC: state_nxt = S_GEN_CNT;
        S_GEN_CNT:  if (gen_last_col) state_nxt = gen_last_row ? S_DONE : S_GEN_RD;
        S_DONE:     if (done_load) state_nxt = S_IDLE;
        default:    state_nxt = S_IDLE;
      endcase
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = RAW'(req_row_r);
    mem_we    = 1'b0;
    mem_waddr = clr_row_r;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_ACC_RD: mem_re = !addr_err;
      S_ACC_MOD: begin
        mem_we    = (req_type_r == REQ_WRITE) && (acc_bit != req_wval_r);
        mem_waddr = RAW'(req_row_r);
        mem_wdata = acc_word;
      end
      S_GEN_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_GEN_RD: begin
        mem_re    = !gen_last_row;
        mem_raddr = RAW'(RW'(gen_row_r) + RW'(1));
      end
      S_GEN_CALC: begin
        mem_we    = 1'b1;
        mem_waddr = gen_row_r;
        mem_wdata = gen_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rows_r      <= RW'(RST_ROWS);
      cols_r      <= CW'(RST_COLS);
      live_cnt_r  <= '0;
      clr_row_r   <= '0;
      clr_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_addr == REG_GRID_ROWS) begin
          rows_r <= rows_clamp;
        end else begin
          cols_r <= cols_clamp;
        end
        live_cnt_r <= '0;
        clr_row_r  <= '0;
        clr_req_r  <= 1'b0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_fire && (req_t'(in_tdata[1:0]) == REQ_CLEAR)) begin
              live_cnt_r <= '0;
              clr_row_r  <= '0;
              clr_req_r  <= 1'b1;
            end
          end
          S_CLEAR: clr_row_r <= clr_row_r + RAW'(1);
          S_ACC_MOD: begin
            if ((req_type_r == REQ_WRITE) && (acc_bit != req_wval_r)) begin
              live_cnt_r <= req_wval_r ? live_cnt_r + LCW'(1) : live_cnt_r - LCW'(1);
            end
          end
          S_GEN_RD0: live_cnt_r <= '0;
          S_GEN_CNT: live_cnt_r <= live_cnt_r + LCW'(new_row_r[0]);
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r <= req_t'(in_tdata[1:0]);
      req_row_r  <= in_tdata[7:2];
      req_col_r  <= in_tdata[13:8];
      req_wval_r <= in_tdata[14];
      res_rd_r   <= 1'b0;
      res_err_r  <= 1'b0;
    end
    unique case (state_r)
      S_ACC_RD: res_err_r <= addr_err;
      S_ACC_MOD: res_rd_r <= (req_type_r == REQ_READ) && acc_bit;
      S_GEN_RD0: gen_row_r <= '0;
      S_GEN_LD0: begin
        prev_r <= '0;
        cur_r  <= mem_rdata_r;
      end
      S_GEN_LD: nxt_r <= gen_last_row ? '0 : mem_rdata_r;
      S_GEN_CALC: begin
        new_row_r <= gen_word;
        prev_r    <= cur_r;
        cur_r     <= nxt_r;
        col_cnt_r <= '0;
      end
      S_GEN_CNT: begin
        new_row_r <= new_row_r >> 1;
        col_cnt_r <= col_cnt_r + CAW'(1);
        if (gen_last_col && !gen_last_row) begin
          gen_row_r <= gen_row_r + RAW'(1);
        end
      end
      default: ;
    endcase
    if (done_load) begin
      out_data_r <= {5'b0, res_err_r, (live_cnt_r != '0), res_rd_r};
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item still in work");

  a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[0])
    else $error("address error result carries a read value");

  a_gen_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && (state_r == S_GEN_CALC) |-> (RW'(gen_row_r) < rows_r))
    else $error("generation write outside rows in use");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_CLEAR) && (state_r != S_CLEAR) |-> (live_cnt_r == '0))
    else $error("live count nonzero after clearing pass");
`endif

endmodule
